/* design/tksd_pkg.sv */
// Shared types, codes and byte constants for the terminal key sequence decoder.
package tksd_pkg;

	// Parser mode while walking through an escape sequence.
	typedef enum logic [1:0] {
		PM_GROUND = 2'd0,
		PM_ESC    = 2'd1,
		PM_CSI    = 2'd2,
		PM_SS3    = 2'd3
	} parse_mode_t;

	// Progress through the CSI modifier number after the first semicolon.
	typedef enum logic [1:0] {
		DP_NONE   = 2'd0,
		DP_SIGN   = 2'd1,
		DP_DIGITS = 2'd2,
		DP_ENDED  = 2'd3
	} digit_phase_t;

	// Sequencer states of the top level.
	typedef enum logic [1:0] {
		CS_IDLE  = 2'd0,
		CS_FEED  = 2'd1,
		CS_FLUSH = 2'd2
	} ctl_state_t;

	// Modifier codes.
	localparam logic [1:0] MOD_NONE  = 2'd0;
	localparam logic [1:0] MOD_SHIFT = 2'd1;
	localparam logic [1:0] MOD_CTRL  = 2'd2;
	localparam logic [1:0] MOD_ALT   = 2'd3;

	// Key kind codes.
	localparam logic [3:0] KIND_CHAR   = 4'd0;
	localparam logic [3:0] KIND_NONE   = 4'd1;
	localparam logic [3:0] KIND_ESCAPE = 4'd2;
	localparam logic [3:0] KIND_BKSP   = 4'd3;
	localparam logic [3:0] KIND_TAB    = 4'd4;
	localparam logic [3:0] KIND_ENTER  = 4'd5;
	localparam logic [3:0] KIND_UP     = 4'd6;
	localparam logic [3:0] KIND_F1     = 4'd10;

	// Byte values the parser looks for.
	localparam logic [7:0] CH_CTL_LO  = 8'h01;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_CTL_HI  = 8'h1A;
	localparam logic [7:0] CH_ESC     = 8'h1B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_1       = 8'h31;
	localparam logic [7:0] CH_2       = 8'h32;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_A       = 8'h41;
	localparam logic [7:0] CH_D       = 8'h44;
	localparam logic [7:0] CH_O       = 8'h4F;
	localparam logic [7:0] CH_P       = 8'h50;
	localparam logic [7:0] CH_S       = 8'h53;
	localparam logic [7:0] CH_Z       = 8'h5A;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_LA      = 8'h61;
	localparam logic [7:0] CH_LZ      = 8'h7A;
	localparam logic [7:0] CH_TILDE   = 8'h7E;
	localparam logic [6:0] CTRL_BIAS  = 7'h40;
	localparam logic [6:0] CASE_BIAS  = 7'h20;
	localparam logic [7:0] NUM_SAT    = 8'hFF;
	localparam logic [7:0] MODNUM_SHIFT = 8'd2;
	localparam logic [7:0] MODNUM_CTRL  = 8'd5;

	// One key event.
	typedef struct packed {
		logic [1:0] modifier;
		logic [3:0] kind;
		logic [6:0] ch;
	} key_event_t;

	// Outcome of feeding one byte to the parser.
	typedef struct packed {
		logic       ev_valid;
		logic       fail;
		key_event_t ev;
	} step_result_t;

endpackage

/* design/tksd_ring_mem.sv */
// Byte ring buffer with one write port and one registered read port.
module tksd_ring_mem #(
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [(1 << AW)];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/tksd_parse.sv */
// Escape sequence parser: per-byte decode and the parser state registers.
module tksd_parse import tksd_pkg::*; #(
	parameter int MAX_SEQ = 16,
	parameter int HCW     = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     c,
	output step_result_t   res,
	output logic [HCW-1:0] held_cnt
);

	localparam logic [HCW-1:0] HC_MAX = HCW'(MAX_SEQ);
	localparam logic [HCW-1:0] HC_ONE = HCW'(1);
	localparam logic [HCW-1:0] HC_TWO = HCW'(2);

	parse_mode_t    mode_q, mode_n;
	digit_phase_t   phase_q, phase_n;
	logic [HCW-1:0] hc_q, hc_n;
	logic           semi_q, semi_n;
	logic [7:0]     mn_q, mn_n;

	logic       is_print, is_upper, is_final, is_arrow, is_digit, is_blank;
	logic [6:0] lowered;
	logic [11:0] num_v;

	always_comb begin
		is_print = (c >= CH_SPACE) && (c <= CH_TILDE);
		is_upper = (c >= CH_A) && (c <= CH_Z);
		is_final = is_upper || ((c >= CH_LA) && (c <= CH_LZ)) || (c == CH_TILDE);
		is_arrow = (c >= CH_A) && (c <= CH_D);
		is_digit = (c >= CH_0) && (c <= CH_9);
		is_blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		lowered  = is_upper ? (c[6:0] + CASE_BIAS) : c[6:0];
		num_v    = ({4'b0, mn_q} << 3) + ({4'b0, mn_q} << 1) + {8'b0, c[3:0]};

		mode_n  = mode_q;
		phase_n = phase_q;
		hc_n    = hc_q;
		semi_n  = semi_q;
		mn_n    = mn_q;
		res     = '0;

		unique case (mode_q)
			PM_GROUND: begin
				priority if (c == CH_ESC) begin
					mode_n = PM_ESC;
					hc_n   = HC_ONE;
				end else if ((c >= CH_CTL_LO) && (c <= CH_CTL_HI)) begin
					res.ev_valid = 1'b1;
					priority if (c == CH_BS) begin
						res.ev.kind = KIND_BKSP;
					end else if (c == CH_TAB) begin
						res.ev.kind = KIND_TAB;
					end else if (c == CH_CR) begin
						res.ev.kind = KIND_ENTER;
					end else begin
						res.ev.modifier = MOD_CTRL;
						res.ev.kind     = KIND_CHAR;
						res.ev.ch       = c[6:0] + CTRL_BIAS;
					end
				end else if (is_print) begin
					res.ev_valid = 1'b1;
					res.ev.kind  = KIND_CHAR;
					priority if (is_upper) begin
						res.ev.modifier = MOD_SHIFT;
						res.ev.ch       = lowered;
					end else if (c == CH_BANG) begin
						res.ev.modifier = MOD_SHIFT;
						res.ev.ch       = CH_1[6:0];
					end else if (c == CH_AT) begin
						res.ev.modifier = MOD_SHIFT;
						res.ev.ch       = CH_2[6:0];
					end else begin
						res.ev.modifier = MOD_NONE;
						res.ev.ch       = c[6:0];
					end
				end else begin
					res.ev_valid = 1'b1;
					res.ev.kind  = KIND_NONE;
				end
			end
			PM_ESC: begin
				priority if ((c == CH_LBRACK) || (c == CH_O)) begin
					mode_n  = (c == CH_LBRACK) ? PM_CSI : PM_SS3;
					hc_n    = HC_TWO;
					semi_n  = 1'b0;
					mn_n    = '0;
					phase_n = DP_NONE;
				end else if (is_print) begin
					res.ev_valid    = 1'b1;
					res.ev.modifier = MOD_ALT;
					res.ev.kind     = KIND_CHAR;
					res.ev.ch       = lowered;
					mode_n          = PM_GROUND;
				end else begin
					res.fail = 1'b1;
				end
			end
			PM_CSI: begin
				if (!is_final) begin
					if (hc_q >= HC_MAX) begin
						res.fail = 1'b1;
					end else begin
						hc_n = hc_q + HC_ONE;
						// Modifier number parsing after the first semicolon.
						priority if (!semi_q) begin
							if (c == CH_SEMI) begin
								semi_n = 1'b1;
							end
						end else if (phase_q == DP_ENDED) begin
							phase_n = phase_q;
						end else if (is_digit) begin
							mn_n    = (num_v > {4'b0, NUM_SAT}) ? NUM_SAT : num_v[7:0];
							phase_n = DP_DIGITS;
						end else if ((phase_q == DP_NONE) && is_blank) begin
							phase_n = phase_q;
						end else if ((phase_q == DP_NONE) && (c == CH_PLUS)) begin
							phase_n = DP_SIGN;
						end else if (phase_q == DP_DIGITS) begin
							phase_n = DP_ENDED;
						end else begin
							mn_n    = '0;
							phase_n = DP_ENDED;
						end
					end
				end else begin
					priority if ((hc_q == HC_TWO) && is_arrow) begin
						res.ev_valid = 1'b1;
						res.ev.kind  = KIND_UP + 4'(c - CH_A);
						mode_n       = PM_GROUND;
					end else if ((hc_q == HC_TWO) && (c == CH_Z)) begin
						res.ev_valid    = 1'b1;
						res.ev.modifier = MOD_SHIFT;
						res.ev.kind     = KIND_TAB;
						mode_n          = PM_GROUND;
					end else if (semi_q && ((phase_q == DP_DIGITS) || (phase_q == DP_ENDED))
							&& is_arrow && ((mn_q == MODNUM_SHIFT) || (mn_q == MODNUM_CTRL))) begin
						res.ev_valid    = 1'b1;
						res.ev.modifier = (mn_q == MODNUM_SHIFT) ? MOD_SHIFT : MOD_CTRL;
						res.ev.kind     = KIND_UP + 4'(c - CH_A);
						mode_n          = PM_GROUND;
					end else begin
						res.fail = 1'b1;
					end
				end
			end
			PM_SS3: begin
				if ((c >= CH_P) && (c <= CH_S)) begin
					res.ev_valid = 1'b1;
					res.ev.kind  = KIND_F1 + 4'(c - CH_P);
					mode_n       = PM_GROUND;
				end else begin
					res.fail = 1'b1;
				end
			end
			default: begin
				mode_n = PM_GROUND;
			end
		endcase

		// A failed sequence reports Escape; a finished one returns to ground.
		if (res.fail) begin
			res.ev_valid = 1'b1;
			res.ev       = '0;
			res.ev.kind  = KIND_ESCAPE;
		end
		if (mode_n == PM_GROUND || res.fail) begin
			mode_n  = PM_GROUND;
			hc_n    = '0;
			semi_n  = 1'b0;
			mn_n    = '0;
			phase_n = DP_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= PM_GROUND;
			phase_q <= DP_NONE;
			hc_q    <= '0;
			semi_q  <= 1'b0;
			mn_q    <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			phase_q <= phase_n;
			hc_q    <= hc_n;
			semi_q  <= semi_n;
			mn_q    <= mn_n;
		end
	end

	assign held_cnt = hc_q;

endmodule

/* design/terminal_key_sequence_decoder.sv */
// Top level of the terminal key sequence decoder: sequencer, replay buffer and output word.
// A new byte is taken only in the idle state, once every key word of the previous byte has left
// the pending slot. After a failed sequence the bytes held after the ESC and the failing byte
// are fed again from the ring buffer; a stalled output holds the sequencer.
// Reset: arst_n puts the parser in ground state and idles the sequencer; no buffer clearing.
module terminal_key_sequence_decoder import tksd_pkg::*; #(
	parameter int MAX_SEQ = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] modifier,
	output logic [3:0] key_kind,
	output logic [6:0] key_char,
	output logic       last_of_run
);

	// The ring buffer holds every byte of the open sequence in order, starting with its ESC,
	// followed by any bytes still waiting to be fed. Its depth is at least twice MAX_SEQ, so
	// a failed sequence replays by moving the read pointer back over its own held bytes.
	localparam int QAW = $clog2(2 * MAX_SEQ);
	localparam int HCW = $clog2(MAX_SEQ + 1);
	localparam int CW  = $clog2(MAX_SEQ + 2);
	localparam int SW  = $clog2(2 * MAX_SEQ + 1);
	localparam logic [CW-1:0] EV_LIMIT = CW'(MAX_SEQ);
	localparam logic [CW-1:0] Q_CLAMP  = CW'(MAX_SEQ + 1);
	localparam logic [SW-1:0] Q_CLAMP_W = SW'(MAX_SEQ + 1);

	ctl_state_t     state_q, state_n;
	logic [QAW-1:0] head_q;
	logic [CW-1:0]  qcnt_q;
	logic [CW-1:0]  ev_cnt_q;
	logic           from_mem_q;
	logic [7:0]     byte_q;
	logic           pend_valid_q;
	key_event_t     pend_q;
	logic           out_valid_q;
	key_event_t     out_ev_q;
	logic           out_last_q;

	logic           accept, feed, push, push_last, set_pend, clr_pend, rd_en, out_busy, more;
	key_event_t     push_ev;
	logic [QAW-1:0] rd_addr, fail_head;
	logic [SW-1:0]  qsum;
	logic [CW-1:0]  qn, ev_cnt_n;
	logic [7:0]     cur_byte, rdata;
	step_result_t   res;
	logic [HCW-1:0] held_cnt;

	tksd_ring_mem #(.AW(QAW)) u_mem (
		.clk   (clk),
		.we    (accept),
		.waddr (head_q),
		.wdata (in_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	// The first byte of an item comes straight from its input register, replayed bytes
	// come from the ring buffer read register.
	assign cur_byte = from_mem_q ? rdata : byte_q;

	tksd_parse #(.MAX_SEQ(MAX_SEQ), .HCW(HCW)) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (feed),
		.c        (cur_byte),
		.res      (res),
		.held_cnt (held_cnt)
	);

	// A failed sequence restarts the queue at the byte after its ESC. The failing byte
	// already sits right behind the held bytes, so only the pointer and count change.
	always_comb begin
		fail_head = head_q - QAW'(held_cnt);
		qsum      = SW'(qcnt_q) + SW'(held_cnt);
		if (res.fail) begin
			qn = (qsum > Q_CLAMP_W) ? Q_CLAMP : CW'(qsum);
		end else begin
			qn = qcnt_q;
		end
		ev_cnt_n = ev_cnt_q + CW'(res.ev_valid);
		more     = (qn != '0) && (ev_cnt_n <= EV_LIMIT);
		out_busy = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and control strobes. A new key word is first parked in the pending slot;
	// it moves to the output word once the next one shows up or the run ends, which is
	// when its last_of_run flag is known.
	always_comb begin
		state_n   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		feed      = 1'b0;
		push      = 1'b0;
		push_last = 1'b0;
		push_ev   = pend_q;
		set_pend  = 1'b0;
		clr_pend  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = res.fail ? fail_head : head_q;
		unique case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid) begin
					state_n = CS_FEED;
				end
			end
			CS_FEED: begin
				if (!(res.ev_valid && pend_valid_q && out_busy)) begin
					feed = 1'b1;
					if (res.ev_valid) begin
						set_pend = 1'b1;
						push     = pend_valid_q;
					end
					if (more) begin
						rd_en = 1'b1;
					end else if (res.ev_valid || pend_valid_q) begin
						state_n = CS_FLUSH;
					end else begin
						state_n = CS_IDLE;
					end
				end
			end
			CS_FLUSH: begin
				if (!out_busy) begin
					push      = 1'b1;
					push_last = 1'b1;
					clr_pend  = 1'b1;
					state_n   = CS_IDLE;
				end
			end
			default: begin
				state_n = CS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			qcnt_q       <= '0;
			ev_cnt_q     <= '0;
			from_mem_q   <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				head_q     <= head_q + QAW'(1);
				qcnt_q     <= '0;
				ev_cnt_q   <= '0;
				from_mem_q <= 1'b0;
			end
			if (feed) begin
				ev_cnt_q <= ev_cnt_n;
				if (rd_en) begin
					head_q     <= rd_addr + QAW'(1);
					qcnt_q     <= qn - CW'(1);
					from_mem_q <= 1'b1;
				end
			end
			if (set_pend) begin
				pend_valid_q <= 1'b1;
			end else if (clr_pend) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_byte;
		end
		if (set_pend) begin
			pend_q <= res.ev;
		end
		if (push) begin
			out_ev_q   <= push_ev;
			out_last_q <= push_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign modifier    = out_ev_q.modifier;
	assign key_kind    = out_ev_q.kind;
	assign key_char    = out_ev_q.ch;
	assign last_of_run = out_last_q;

`ifndef NO_ASSERTIONS
	// A new byte is only taken once every word of the previous one has left the pending slot.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !pend_valid_q)
		else $error("byte accepted while a key word is still pending");

	// The run of one byte never produces more than MAX_SEQ + 1 words.
	a_event_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ev_cnt_q <= Q_CLAMP)
		else $error("key word count of one byte out of range");

	// Bytes waiting for replay never exceed what one failed sequence can leave behind.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= EV_LIMIT)
		else $error("replay queue count out of range");

	// The open sequence never holds more than MAX_SEQ bytes.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_cnt <= HCW'(MAX_SEQ))
		else $error("held sequence longer than MAX_SEQ");

	// An accepted byte is decoded in the very next cycle.
	a_accept_feeds: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == CS_FEED) && !from_mem_q)
		else $error("accepted byte not decoded next cycle");
`endif

endmodule

/* bench/tb_terminal_key_sequence_decoder.sv */
// Self-checking testbench for the terminal key sequence decoder with a built-in key predictor.
module tb_terminal_key_sequence_decoder import tksd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Sequence length limit of the decoder under test. The predictor uses the same value.
	localparam int SEQ_LIMIT = 16;

	// Cycles in which no word moves on either side before the run is declared hung.
	// The longest quiet stretch in a correct run is the receiver hold-off, so this
	// leaves ample margin.
	localparam int QUIET_LIMIT = 3000;

	// Cycles to keep watching after the last expected key word has arrived. A byte
	// that makes no key word may still be replaying held bytes at that point.
	localparam int DRAIN_CYCLES = 40;

	// Least number of random bytes planned per idling phase.
	localparam int BYTES_PER_PHASE = 78;

	// Bytes the decoder has no named constant for.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// Directed opening: extremes of the byte range, every control class, shifted
	// characters, a CSI arrow, an SS3 key, an Alt character and a modified arrow. The escape
	// followed by a carriage return exercises the escape-then-non-printable path.
	localparam logic [7:0] DIRECTED [27] = '{
		8'h00, 8'hFF, CH_DEL, CH_CTL_LO, CH_BS, CH_TAB, CH_CR, CH_CTL_HI,
		CH_A, CH_BANG, CH_AT, CH_TILDE,
		CH_ESC, CH_LBRACK, CH_D,
		CH_ESC, CH_O, CH_S,
		CH_ESC, CH_Z,
		CH_ESC, CH_CR,
		CH_ESC, CH_LBRACK, CH_SEMI, CH_0 + MODNUM_CTRL, CH_A
	};

	// The scoreboard holds its own copy of the parser state. Each accepted input
	// byte is run through the predictor, and the key words it makes are queued in
	// order; each key word leaving the block is compared with the oldest one.
	class key_word_scoreboard;
		typedef struct packed {
			key_event_t ev;
			logic       last;
		} key_word_t;

		key_word_t    expected_words[$];
		key_word_t    run[$];
		logic [7:0]   replay[$];
		int           failures;

		parse_mode_t  mode;
		logic [7:0]   held [SEQ_LIMIT];
		int           held_n;
		logic         semi_seen;
		int           mod_num;
		digit_phase_t num_phase;

		function new();
			failures = 0;
			return_to_ground();
		endfunction

		function void return_to_ground();
			mode = PM_GROUND;
			held_n = 0;
			semi_seen = 1'b0;
			mod_num = 0;
			num_phase = DP_NONE;
		endfunction

		function void emit(logic [1:0] m, logic [3:0] k, logic [6:0] c);
			key_word_t w;
			w.ev.modifier = m;
			w.ev.kind = k;
			w.ev.ch = c;
			w.last = 1'b0;
			run = {run, w};
		endfunction

		// A failed sequence gives Escape, then the bytes held after the ESC, the
		// current byte and whatever was still waiting are decoded again.
		function void abort_sequence(logic [7:0] c);
			logic [7:0] tmp[$];
			emit(MOD_NONE, KIND_ESCAPE, 7'd0);
			for (int i = 1; i < held_n && i < SEQ_LIMIT; i++)
				tmp = {tmp, held[i]};
			tmp = {tmp, c};
			tmp = {tmp, replay};
			while (tmp.size() > SEQ_LIMIT + 1)
				void'(tmp.pop_back());
			replay = tmp;
			return_to_ground();
		endfunction

		function void decode_ground(logic [7:0] c);
			if (c == CH_ESC) begin
				held[0] = c;
				held_n = 1;
				mode = PM_ESC;
			end else if (c >= CH_CTL_LO && c <= CH_CTL_HI) begin
				if (c == CH_BS)
					emit(MOD_NONE, KIND_BKSP, 7'd0);
				else if (c == CH_TAB)
					emit(MOD_NONE, KIND_TAB, 7'd0);
				else if (c == CH_CR)
					emit(MOD_NONE, KIND_ENTER, 7'd0);
				else
					emit(MOD_CTRL, KIND_CHAR, c[6:0] + CTRL_BIAS);
			end else if (c >= CH_SPACE && c <= CH_TILDE) begin
				if (c >= CH_A && c <= CH_Z)
					emit(MOD_SHIFT, KIND_CHAR, c[6:0] + CASE_BIAS);
				else if (c == CH_BANG)
					emit(MOD_SHIFT, KIND_CHAR, CH_1[6:0]);
				else if (c == CH_AT)
					emit(MOD_SHIFT, KIND_CHAR, CH_2[6:0]);
				else
					emit(MOD_NONE, KIND_CHAR, c[6:0]);
			end else begin
				emit(MOD_NONE, KIND_NONE, 7'd0);
			end
		endfunction

		// Modifier number after the first semicolon: blanks, an optional plus sign,
		// then digits saturating at 255. Anything else spoils or ends the number.
		function void track_number(logic [7:0] c);
			int v;
			if (!semi_seen) begin
				if (c == CH_SEMI)
					semi_seen = 1'b1;
				return;
			end
			if (num_phase == DP_ENDED)
				return;
			if (c >= CH_0 && c <= CH_9) begin
				v = mod_num * 10 + int'(c - CH_0);
				mod_num = (v > 255) ? 255 : v;
				num_phase = DP_DIGITS;
			end else if (num_phase == DP_NONE && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
				// Leading blank, skipped.
			end else if (num_phase == DP_NONE && c == CH_PLUS) begin
				num_phase = DP_SIGN;
			end else if (num_phase == DP_DIGITS) begin
				num_phase = DP_ENDED;
			end else begin
				mod_num = 0;
				num_phase = DP_ENDED;
			end
		endfunction

		function void decode_csi(logic [7:0] c);
			logic is_final;
			is_final = (c >= CH_A && c <= CH_Z) || (c >= CH_LA && c <= CH_LZ) || c == CH_TILDE;
			if (!is_final) begin
				if (held_n >= SEQ_LIMIT) begin
					abort_sequence(c);
					return;
				end
				held[held_n] = c;
				held_n++;
				track_number(c);
				return;
			end
			if (held_n == 2 && c >= CH_A && c <= CH_D) begin
				emit(MOD_NONE, KIND_UP + 4'(c - CH_A), 7'd0);
				return_to_ground();
			end else if (held_n == 2 && c == CH_Z) begin
				emit(MOD_SHIFT, KIND_TAB, 7'd0);
				return_to_ground();
			end else if (semi_seen && num_phase >= DP_DIGITS && c >= CH_A && c <= CH_D &&
				(mod_num == int'(MODNUM_SHIFT) || mod_num == int'(MODNUM_CTRL))) begin
				emit((mod_num == int'(MODNUM_SHIFT)) ? MOD_SHIFT : MOD_CTRL,
					KIND_UP + 4'(c - CH_A), 7'd0);
				return_to_ground();
			end else begin
				abort_sequence(c);
			end
		endfunction

		function void decode_byte(logic [7:0] c);
			case (mode)
			PM_GROUND: decode_ground(c);
			PM_ESC: begin
				if (c == CH_LBRACK || c == CH_O) begin
					held[1] = c;
					held_n = 2;
					mode = (c == CH_LBRACK) ? PM_CSI : PM_SS3;
					semi_seen = 1'b0;
					mod_num = 0;
					num_phase = DP_NONE;
				end else if (c >= CH_SPACE && c <= CH_TILDE) begin
					emit(MOD_ALT, KIND_CHAR,
						(c >= CH_A && c <= CH_Z) ? c[6:0] + CASE_BIAS : c[6:0]);
					return_to_ground();
				end else begin
					abort_sequence(c);
				end
			end
			PM_CSI: decode_csi(c);
			default: begin
				if (c >= CH_P && c <= CH_S) begin
					emit(MOD_NONE, KIND_F1 + 4'(c - CH_P), 7'd0);
					return_to_ground();
				end else begin
					abort_sequence(c);
				end
			end
			endcase
		endfunction

		// Called for every accepted input word. Replays stop once a byte has made
		// one more key word than the sequence limit.
		function void note_byte(logic [7:0] b);
			run.delete();
			replay.delete();
			replay = {replay, b};
			while (replay.size() > 0 && run.size() <= SEQ_LIMIT)
				decode_byte(replay.pop_front());
			if (run.size() > 0)
				run[run.size() - 1].last = 1'b1;
			foreach (run[i])
				expected_words = {expected_words, run[i]};
		endfunction

		function void check_word(logic [1:0] m, logic [3:0] k, logic [6:0] c, logic l);
			key_word_t w;
			if (expected_words.size() == 0) begin
				$error("key word with nothing expected: modifier %0d key_kind %0d key_char %0d",
					m, k, c);
				failures++;
				return;
			end
			w = expected_words.pop_front();
			if (m !== w.ev.modifier) begin
				$error("modifier: expected %0d, actual %0d", w.ev.modifier, m);
				failures++;
			end
			if (k !== w.ev.kind) begin
				$error("key_kind: expected %0d, actual %0d", w.ev.kind, k);
				failures++;
			end
			if (c !== w.ev.ch) begin
				$error("key_char: expected %0d, actual %0d", w.ev.ch, c);
				failures++;
			end
			if (l !== w.last) begin
				$error("last_of_run: expected %0d, actual %0d", w.last, l);
				failures++;
			end
		endfunction

		function int pending();
			return expected_words.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [1:0] modifier;
	logic [3:0] key_kind;
	logic [6:0] key_char;
	logic       last_of_run;

	key_word_scoreboard sb;

	// Idling controls, set by the main sequence for each phase.
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int quiet_cycles;

	// Bytes planned for the current phase.
	logic [7:0] plan[$];

	terminal_key_sequence_decoder #(
		.MAX_SEQ(SEQ_LIMIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.modifier(modifier),
		.key_kind(key_kind),
		.key_char(key_char),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver side. A requested hold-off is counted down here, one cycle per
	// falling edge, while the sender keeps offering bytes; otherwise ready is
	// dropped at random according to the phase's stall rate.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// Outputs are sampled at the rising edge. The same block watches for a hang:
	// a long run of cycles with no word moving on either side ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_word(modifier, key_kind, key_char, last_of_run);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[terminal_key_sequence_decoder] ERROR");
				$finish;
			end
		end
	end

	// Offers one input word, starting at a falling edge. Idle cycles drop valid
	// first; once valid rises it stays up with the byte unchanged until accepted.
	// Valid is only lowered by the next idle cycle or at the end of the run, so it
	// never gets two assignments in one time step.
	task automatic offer_byte(logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_byte(b);
		@(negedge clk);
	endtask

	// Appends one byte to the plan of the current phase.
	function automatic void plan_add(logic [7:0] b);
		plan = {plan, b};
	endfunction

	// Any byte that keeps a CSI sequence open.
	function automatic logic [7:0] open_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(0, 255));
		while ((b >= CH_A && b <= CH_Z) || (b >= CH_LA && b <= CH_LZ) || b == CH_TILDE);
		return b;
	endfunction

	// Sequence terminator: often an arrow letter, sometimes Z, a lower-case letter, a
	// tilde or another upper-case letter, some of which the decoder does not know.
	function automatic logic [7:0] closing_byte();
		case ($urandom_range(0, 6))
		0, 1, 2: return CH_A + 8'($urandom_range(0, 3));
		3:       return CH_Z;
		4:       return CH_LA + 8'($urandom_range(0, 25));
		5:       return CH_TILDE;
		default: return CH_A + 8'($urandom_range(0, 25));
		endcase
	endfunction

	// Appends one random fragment to the plan. Most fragments are escape sequences,
	// well-formed or broken, with random content, so the CSI number parser and the
	// replay path get real exercise; the rest are single bytes.
	task automatic plan_sequence();
		int         num;
		int         blanks;
		logic [7:0] digs[$];
		case ($urandom_range(0, 11))
		0: plan_add(8'($urandom_range(0, 255)));
		1: plan_add(8'($urandom_range(CH_SPACE, CH_TILDE)));
		2: plan_add(8'($urandom_range(0, CH_SPACE)));
		3: begin
			plan_add(CH_ESC);
			plan_add(8'($urandom_range(0, 255)));
		end
		4: begin
			plan_add(CH_ESC);
			plan_add(CH_LBRACK);
			plan_add(closing_byte());
		end
		5, 6, 7: begin
			// Modified arrow, with blanks, signs, leading zeros, saturating and
			// missing numbers, and trailing junk mixed in.
			plan_add(CH_ESC);
			plan_add(CH_LBRACK);
			if ($urandom_range(0, 3) == 0)
				plan_add(CH_1);
			if ($urandom_range(0, 7) != 0)
				plan_add(CH_SEMI);
			blanks = $urandom_range(0, 2);
			repeat (blanks)
				plan_add($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
			case ($urandom_range(0, 9))
			0: plan_add(CH_PLUS);
			1: plan_add(CH_MINUS);
			default: ;
			endcase
			case ($urandom_range(0, 5))
			0, 1: num = int'(MODNUM_SHIFT);
			2, 3: num = int'(MODNUM_CTRL);
			4:    num = $urandom_range(0, 999);
			default: num = $urandom_range(256, 99999);
			endcase
			if ($urandom_range(0, 9) != 0) begin
				do begin
					digs.push_front(CH_0 + 8'(num % 10));
					num = num / 10;
				end while (num > 0);
				if ($urandom_range(0, 3) == 0)
					digs.push_front(CH_0);
				plan = {plan, digs};
			end
			if ($urandom_range(0, 4) == 0)
				plan_add(open_byte());
			plan_add(closing_byte());
		end
		8: begin
			plan_add(CH_ESC);
			plan_add(CH_O);
			if ($urandom_range(0, 3) != 0)
				plan_add(CH_P + 8'($urandom_range(0, 3)));
			else
				plan_add(8'($urandom_range(0, 255)));
		end
		9: begin
			// Overlong: the open bytes bring the sequence near or past its limit before the final.
			plan_add(CH_ESC);
			plan_add(CH_LBRACK);
			repeat ($urandom_range(SEQ_LIMIT - 4, SEQ_LIMIT + 2))
				plan_add(open_byte());
			plan_add(closing_byte());
		end
		10: begin
			// Broken: a new ESC arrives inside an open sequence.
			plan_add(CH_ESC);
			plan_add(CH_LBRACK);
			repeat ($urandom_range(0, 3))
				plan_add(open_byte());
			plan_add(CH_ESC);
		end
		default: begin
			case ($urandom_range(0, 3))
			0: plan_add(CH_BANG);
			1: plan_add(CH_AT);
			2: plan_add(8'($urandom_range(CH_CTL_LO, CH_CTL_HI)));
			default: plan_add(8'($urandom_range(CH_A, CH_Z)));
			endcase
		end
		endcase
	endtask

	// Main sequence: reset, directed bytes, then four idling phases of random
	// fragments, and a drain before the verdict.
	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		quiet_cycles = 0;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (DIRECTED[i])
			offer_byte(DIRECTED[i]);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				// No idling, but the receiver holds off for a long stretch first
				// so the decoder fills up and stalls its input.
				send_idle_pct = 0;
				recv_stall_pct = 0;
				hold_left = 300;
			end
			1: begin
				send_idle_pct = 80;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 80;
			end
			default: begin
				send_idle_pct = 9;
				recv_stall_pct = 9;
			end
			endcase
			plan.delete();
			while (plan.size() < BYTES_PER_PHASE)
				plan_sequence();
			foreach (plan[i])
				offer_byte(plan[i]);
		end
		in_valid <= 1'b0;

		// The watchdog bounds this wait.
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (sb.failures == 0)
			$display("[terminal_key_sequence_decoder] OK");
		else
			$display("[terminal_key_sequence_decoder] ERROR");
		$finish;
	end

endmodule

/* terminal_key_sequence_decoder.f */
design/tksd_pkg.sv
design/tksd_ring_mem.sv
design/tksd_parse.sv
design/terminal_key_sequence_decoder.sv
bench/tb_terminal_key_sequence_decoder.sv
